FILE: design/tdz_pkg.sv
// Shared types and constants for the thumbstick dead-zone unit.
package tdz_pkg;

	// Zone mode codes; the unused code behaves as no dead zone
	localparam logic [1:0] ZONE_INDEP = 2'd0;
	localparam logic [1:0] ZONE_CIRC  = 2'd1;
	localparam logic [1:0] ZONE_NONE  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_ZONE_MODE  = 2'd0;
	localparam logic [1:0] CFG_DEAD_ZONE  = 2'd1;
	localparam logic [1:0] CFG_FULL_SCALE = 2'd2;

	// Register reset values
	localparam logic [14:0] DEAD_ZONE_RST  = 15'd7864;
	localparam logic [14:0] FULL_SCALE_RST = 15'd32767;

	// Datapath widths: squared length, axis magnitude, divider remainder
	localparam int SQ_W   = 32;
	localparam int MAG_W  = 17;
	localparam int DIV_W  = 17;
	localparam int ROOT_STEPS = 16;

	// Square root partial state handed from cell to cell
	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_t;

	// Per-sample sideband carried along the chain
	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic             sx;
		logic             sy;
		logic             circ;
		logic             use_dz;
	} side_t;

endpackage

FILE: design/thumbstick_dead_zone_unit.sv
// Thumbstick dead-zone unit: top level with config, cell chains and output stage.
//
// Usage:
//   Input: drive stick_x / stick_y and raise start; a sample transfers at each
//   clock edge with start high and busy low. busy stays low, so one sample
//   can be taken every cycle.
//   Output: each result appears on out_x / out_y for one cycle with done
//   high; the receiver cannot hold it off, and none is needed since the
//   chain never stalls.
//   Config: cfg_valid / cfg_ready write channel, cfg_index selects
//   zone_mode (0), dead_zone (1) or full_scale (2); other indexes are
//   dropped. cfg_ready is always high. Write only while no sample is in flight.
//   Path: from start to done a sample passes the input stage, the 16 square-root
//   cells, the zone prep stage, FRAC_BITS zone division cells, the rescale
//   stage, FRAC_BITS + 1 rescale division cells and the output register.
//   Throughput: one sample per cycle, in every mode.
//   Reset: arst_n clears the valid line and loads the register defaults;
//   in-flight samples are discarded.
module thumbstick_dead_zone_unit
	import tdz_pkg::*;
#(
	parameter int FRAC_BITS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] stick_x,
	input  logic signed [15:0] stick_y,
	output logic               done,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int F      = FRAC_BITS;
	localparam int QW     = F + 1;
	localparam int NTOT   = MAG_W + QW;
	localparam int CW     = (QW > MAG_W) ? QW : MAG_W;
	localparam int P_PREP = ROOT_STEPS + 1;
	localparam int P_DIV1 = P_PREP + F;
	localparam int P_MUL  = P_DIV1 + 1;
	localparam int P_DIV2 = P_MUL + QW;
	localparam logic [CW-1:0] ONE_C   = CW'(1) << F;
	localparam logic [CW-1:0] POS_LIM = (F >= 15) ? CW'(32767) : (ONE_C - CW'(1));
	localparam logic [CW-1:0] NEG_LIM = (F >= 15) ? CW'(32768) : ONE_C;

	logic [1:0]  zone_mode_q;
	logic [14:0] dead_zone_q;
	logic [14:0] full_scale_q;

	logic        vld_q  [0:P_DIV2];
	side_t       side_q [0:P_DIV2];
	sqrt_t       root_line [0:ROOT_STEPS];

	// Zone division chain, two lanes
	logic [DIV_W-1:0] r1x [0:F];
	logic [DIV_W-1:0] d1x [0:F];
	logic [F-1:0]     q1x [0:F];
	logic [DIV_W-1:0] r1y [0:F];
	logic [DIV_W-1:0] d1y [0:F];
	logic [F-1:0]     q1y [0:F];
	logic             zx_q [0:F];
	logic             sx_q [0:F];
	logic             zy_q [0:F];
	logic             sy_q [0:F];
	logic [MAG_W-1:0] dist_q [0:F];

	// Rescale division chain, two lanes
	logic [DIV_W-1:0] r2x [0:QW];
	logic [DIV_W-1:0] d2x [0:QW];
	logic [QW-1:0]    q2x [0:QW];
	logic [DIV_W-1:0] r2y [0:QW];
	logic [DIV_W-1:0] d2y [0:QW];
	logic [QW-1:0]    q2y [0:QW];
	logic [F:0]       wx_q [0:QW];
	logic [F:0]       wy_q [0:QW];
	logic             cz_q [0:QW];

	logic             done_q;
	logic [15:0]      out_x_q;
	logic [15:0]      out_y_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_mode_q  <= ZONE_INDEP;
			dead_zone_q  <= DEAD_ZONE_RST;
			full_scale_q <= FULL_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ZONE_MODE:  zone_mode_q  <= cfg_data[1:0];
				CFG_DEAD_ZONE:  dead_zone_q  <= cfg_data[14:0];
				CFG_FULL_SCALE: full_scale_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Valid line through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= P_DIV2; i++) vld_q[i] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i <= P_DIV2; i++) vld_q[i] <= vld_q[i-1];
			done_q <= vld_q[P_DIV2];
		end
	end

	// Input stage: magnitudes, signs, mode decode and squared length
	logic signed [31:0] sqx, sqy;
	side_t              side_in;
	always_comb begin
		sqx = 32'(stick_x) * 32'(stick_x);
		sqy = 32'(stick_y) * 32'(stick_y);
		side_in.sx     = stick_x[15];
		side_in.sy     = stick_y[15];
		side_in.ax     = stick_x[15] ? MAG_W'(-17'(stick_x)) : MAG_W'(stick_x);
		side_in.ay     = stick_y[15] ? MAG_W'(-17'(stick_y)) : MAG_W'(stick_y);
		side_in.circ   = zone_mode_q == ZONE_CIRC;
		side_in.use_dz = zone_mode_q == ZONE_INDEP;
	end

	always_ff @(posedge clk) begin
		side_q[0]         <= side_in;
		root_line[0].rem  <= SQ_W'(sqx) + SQ_W'(sqy);
		root_line[0].root <= '0;
		for (int i = 1; i <= P_DIV2; i++) side_q[i] <= side_q[i-1];
	end

	// Square root cells
	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sqrt
		tdz_sqrt_cell #(.BIT_POS(SQ_W - 2 - 2 * k)) u_cell (
			.clk  (clk),
			.din  (root_line[k]),
			.dout (root_line[k+1])
		);
	end

	// Zone prep: subtract the dead zone, flag zero and saturation
	side_t            sp;
	logic [14:0]      dzv;
	logic [MAG_W-1:0] vx, vy, mx, my, den;
	logic             den_pos;
	always_comb begin
		sp      = side_q[ROOT_STEPS];
		dzv     = sp.use_dz || sp.circ ? dead_zone_q : 15'd0;
		vx      = sp.circ ? root_line[ROOT_STEPS].root[MAG_W-1:0] : sp.ax;
		vy      = sp.ay;
		mx      = vx - MAG_W'(dzv);
		my      = vy - MAG_W'(dzv);
		den_pos = full_scale_q > dzv;
		den     = den_pos ? MAG_W'(full_scale_q - dzv) : MAG_W'(1);
	end

	always_ff @(posedge clk) begin
		zx_q[0]   <= !(vx > MAG_W'(dzv));
		zy_q[0]   <= !(vy > MAG_W'(dzv));
		sx_q[0]   <= !den_pos || (mx >= den);
		sy_q[0]   <= !den_pos || (my >= den);
		r1x[0]    <= (vx > MAG_W'(dzv) && den_pos && mx < den) ? mx : '0;
		r1y[0]    <= (vy > MAG_W'(dzv) && den_pos && my < den) ? my : '0;
		d1x[0]    <= den;
		d1y[0]    <= den;
		q1x[0]    <= '0;
		q1y[0]    <= '0;
		dist_q[0] <= root_line[ROOT_STEPS].root[MAG_W-1:0];
		for (int i = 1; i <= F; i++) begin
			zx_q[i]   <= zx_q[i-1];
			zy_q[i]   <= zy_q[i-1];
			sx_q[i]   <= sx_q[i-1];
			sy_q[i]   <= sy_q[i-1];
			dist_q[i] <= dist_q[i-1];
		end
	end

	for (genvar k = 0; k < F; k++) begin : g_div1
		tdz_div_cell #(.DW(DIV_W), .NW(F)) u_x (
			.clk(clk), .rem_in(r1x[k]), .div_in(d1x[k]), .nq_in(q1x[k]),
			.rem_out(r1x[k+1]), .div_out(d1x[k+1]), .nq_out(q1x[k+1])
		);
		tdz_div_cell #(.DW(DIV_W), .NW(F)) u_y (
			.clk(clk), .rem_in(r1y[k]), .div_in(d1y[k]), .nq_in(q1y[k]),
			.rem_out(r1y[k+1]), .div_out(d1y[k+1]), .nq_out(q1y[k+1])
		);
	end

	// Wanted values and rescale products
	logic [F:0]       wx, wy;
	logic [NTOT-1:0]  nx, ny;
	logic [MAG_W-1:0] dist_v;
	logic             czero;
	always_comb begin
		wx     = zx_q[F] ? '0 : (sx_q[F] ? (F+1)'(1) << F : {1'b0, q1x[F]});
		wy     = zy_q[F] ? '0 : (sy_q[F] ? (F+1)'(1) << F : {1'b0, q1y[F]});
		dist_v = dist_q[F];
		czero  = (wx == '0) || (dist_v == '0);
		nx     = NTOT'(side_q[P_DIV1].ax) * NTOT'(wx);
		ny     = NTOT'(side_q[P_DIV1].ay) * NTOT'(wx);
	end

	always_ff @(posedge clk) begin
		r2x[0]  <= czero ? '0 : nx[NTOT-1:QW];
		r2y[0]  <= czero ? '0 : ny[NTOT-1:QW];
		q2x[0]  <= nx[QW-1:0];
		q2y[0]  <= ny[QW-1:0];
		d2x[0]  <= czero ? DIV_W'(1) : dist_v;
		d2y[0]  <= czero ? DIV_W'(1) : dist_v;
		wx_q[0] <= wx;
		wy_q[0] <= wy;
		cz_q[0] <= czero;
		for (int i = 1; i <= QW; i++) begin
			wx_q[i] <= wx_q[i-1];
			wy_q[i] <= wy_q[i-1];
			cz_q[i] <= cz_q[i-1];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div2
		tdz_div_cell #(.DW(DIV_W), .NW(QW)) u_x (
			.clk(clk), .rem_in(r2x[k]), .div_in(d2x[k]), .nq_in(q2x[k]),
			.rem_out(r2x[k+1]), .div_out(d2x[k+1]), .nq_out(q2x[k+1])
		);
		tdz_div_cell #(.DW(DIV_W), .NW(QW)) u_y (
			.clk(clk), .rem_in(r2y[k]), .div_in(d2y[k]), .nq_in(q2y[k]),
			.rem_out(r2y[k+1]), .div_out(d2y[k+1]), .nq_out(q2y[k+1])
		);
	end

	// Output stage: pick magnitude, clamp, apply sign
	side_t         so;
	logic [CW-1:0] magx, magy, limx, limy, clx, cly;
	always_comb begin
		so   = side_q[P_DIV2];
		magx = so.circ ? (cz_q[QW] ? '0 : CW'(q2x[QW])) : CW'(wx_q[QW]);
		magy = so.circ ? (cz_q[QW] ? '0 : CW'(q2y[QW])) : CW'(wy_q[QW]);
		limx = so.sx ? NEG_LIM : POS_LIM;
		limy = so.sy ? NEG_LIM : POS_LIM;
		clx  = (magx > limx) ? limx : magx;
		cly  = (magy > limy) ? limy : magy;
	end

	always_ff @(posedge clk) begin
		out_x_q <= so.sx ? 16'(-clx[15:0]) : clx[15:0];
		out_y_q <= so.sy ? 16'(-cly[15:0]) : cly[15:0];
	end

endmodule

FILE: design/tdz_sqrt_cell.sv
// One digit-pair step of the integer square root chain.
module tdz_sqrt_cell
	import tdz_pkg::*;
#(
	parameter int BIT_POS = 30
) (
	input  logic  clk,
	input  sqrt_t din,
	output sqrt_t dout
);

	localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << BIT_POS;

	logic [SQ_W-1:0] trial;
	sqrt_t           nxt;

	// Try the next root bit, keep it when the remainder covers it
	always_comb begin
		trial = din.root + STEP_BIT;
		if (din.rem >= trial) begin
			nxt.rem  = din.rem - trial;
			nxt.root = (din.root >> 1) + STEP_BIT;
		end else begin
			nxt.rem  = din.rem;
			nxt.root = din.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

FILE: design/tdz_div_cell.sv
// One restoring-division step: shift in a numerator bit, emit a quotient bit.
module tdz_div_cell #(
	parameter int DW = 17,
	parameter int NW = 16
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_in,
	input  logic [DW-1:0] div_in,
	input  logic [NW-1:0] nq_in,
	output logic [DW-1:0] rem_out,
	output logic [DW-1:0] div_out,
	output logic [NW-1:0] nq_out
);

	logic [DW:0] trial;
	logic        ge;

	// Compare the shifted remainder against the divisor
	always_comb begin
		trial = {rem_in, nq_in[NW-1]};
		ge    = trial >= {1'b0, div_in};
	end

	// Advance remainder, divisor and numerator/quotient word
	always_ff @(posedge clk) begin
		rem_out <= ge ? DW'(trial - {1'b0, div_in}) : trial[DW-1:0];
		div_out <= div_in;
		nq_out  <= {nq_in[NW-2:0], ge};
	end

endmodule
